### rtl/core/rlp_pkg.sv
package rlp_pkg;

  typedef enum logic [1:0] {
    ACT_STRING = 2'd0,
    ACT_LIST   = 2'd1,
    ACT_INT    = 2'd2,
    ACT_NONE   = 2'd3
  } rlp_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HEAD,
    ST_BODY,
    ST_TAIL
  } rlp_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] item_length;
    logic [7:0]  data_byte;
    logic [63:0] value_word3;
    logic [63:0] value_word2;
    logic [63:0] value_word1;
    logic [63:0] value_word0;
  } rlp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } rlp_out_t;

  localparam logic [7:0]  STR_OFFSET  = 8'h80;
  localparam logic [7:0]  LIST_OFFSET = 8'hc0;
  localparam logic [7:0]  SINGLE_MAX  = 8'h80;
  localparam logic [7:0]  LONG_BASE   = 8'd55;
  localparam logic [31:0] SHORT_LIMIT = 32'd56;

endpackage

### rtl/core/rlp_item_encoder.sv
// rlp_item_encoder: RLP byte-stream encoder.
// item channel (item_valid/item_ready, payload item) takes one request at a time:
//   string byte, list header or 256-bit integer. item_ready is high only while
//   the sequencer is idle, so one request is worked on at a time.
// result channel (result_valid/result_ready, payload result) gives one encoded
//   byte per transfer; run_last marks the final byte caused by a request.
// sequence: an open-string byte passes through the head byte register, then the
//   result register. a string start or list header gives a header byte, then n
//   length bytes (n = 0 for short lengths, else 1 to 4); a string start then gives
//   its first payload byte. an integer first runs a leading-zero scan in a shared
//   byte compare/shift unit, one byte per cycle, then gives a prefix and its k
//   significant bytes (one byte for 0 or below 0x80), one per cycle while unstalled.
// the result register lets a new request be taken while the last byte still
//   waits; while the receiver stalls, the sequencer holds and no request is
//   taken until the last byte of the current one is in the result register.
// reset clears the sequencer, the result valid flag and the open string count.
module rlp_item_encoder
  import rlp_pkg::*;
#(
  parameter int LENGTH_BYTES  = 4,
  parameter int INTEGER_BYTES = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  rlp_in_t  item,
  output logic     result_valid,
  input  logic     result_ready,
  output rlp_out_t result
);

  localparam int LB       = (LENGTH_BYTES < 1) ? 1 : ((LENGTH_BYTES > 8) ? 8 : LENGTH_BYTES);
  localparam int NB       = (INTEGER_BYTES < 1) ? 1 :
                            ((INTEGER_BYTES > 32) ? 32 : INTEGER_BYTES);
  localparam int LEN_BITS = (LB >= 4) ? 32 : 8 * LB;
  localparam int SH_BYTES = (NB > 4) ? NB : 4;
  localparam int SH_W     = 8 * SH_BYTES;
  localparam int CNT_W    = $clog2(SH_BYTES + 1);

  rlp_state_t          state, state_next;
  logic [LEN_BITS-1:0] rem, rem_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [SH_W-1:0]     sh, sh_next;
  logic [7:0]          head_byte, head_next;
  logic                tail_en, tail_en_next;
  logic [7:0]          tail_byte, tail_next;
  logic                result_valid_next;

  logic                can_load, load, load_last;
  logic [7:0]          load_byte;
  logic [31:0]         len_cut;
  logic [2:0]          len_n;
  logic [31:0]         len_left;
  logic [SH_W-1:0]     len_al;
  logic [255:0]        ival_all;
  logic [SH_W-1:0]     int_al;
  logic                len_long;
  logic [7:0]          hdr_base;
  logic [CNT_W-1:0]    hdr_cnt;
  logic [7:0]          sh_top;

  assign len_cut  = 32'(item.item_length[LEN_BITS-1:0]);
  assign len_long = (len_cut >= SHORT_LIMIT);
  assign ival_all = {item.value_word3, item.value_word2, item.value_word1, item.value_word0};
  assign int_al   = SH_W'(ival_all[8*NB-1:0]) << (SH_W - 8 * NB);
  assign sh_top   = sh[SH_W-1 -: 8];
  assign can_load = !result_valid || result_ready;

  // number of significant length bytes, left-aligned so the top byte goes first
  always_comb begin
    if (len_cut[31:24] != 8'd0) begin
      len_n    = 3'd4;
      len_left = len_cut;
    end else if (len_cut[23:16] != 8'd0) begin
      len_n    = 3'd3;
      len_left = len_cut << 8;
    end else if (len_cut[15:8] != 8'd0) begin
      len_n    = 3'd2;
      len_left = len_cut << 16;
    end else begin
      len_n    = 3'd1;
      len_left = len_cut << 24;
    end
  end

  assign len_al   = SH_W'(len_left) << (SH_W - 32);
  assign hdr_base = len_long ? (LONG_BASE + 8'(len_n)) : len_cut[7:0];
  assign hdr_cnt  = len_long ? CNT_W'(len_n) : '0;

  always_comb begin
    state_next   = state;
    rem_next     = rem;
    cnt_next     = cnt;
    sh_next      = sh;
    head_next    = head_byte;
    tail_en_next = tail_en;
    tail_next    = tail_byte;
    load         = 1'b0;
    load_byte    = head_byte;
    load_last    = 1'b0;
    item_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          case (item.action)
            ACT_STRING: begin
              tail_en_next = 1'b0;
              cnt_next     = '0;
              state_next   = ST_HEAD;
              if (rem != '0) begin
                head_next = item.data_byte;
                rem_next  = rem - LEN_BITS'(1);
              end else if (len_cut == 32'd0) begin
                head_next = STR_OFFSET;
              end else if (len_cut == 32'd1 && item.data_byte < SINGLE_MAX) begin
                head_next = item.data_byte;
              end else begin
                head_next    = STR_OFFSET + hdr_base;
                cnt_next     = hdr_cnt;
                sh_next      = len_al;
                tail_en_next = 1'b1;
                tail_next    = item.data_byte;
                rem_next     = LEN_BITS'(len_cut - 32'd1);
              end
            end
            ACT_LIST: begin
              head_next    = LIST_OFFSET + hdr_base;
              cnt_next     = hdr_cnt;
              sh_next      = len_al;
              tail_en_next = 1'b0;
              state_next   = ST_HEAD;
            end
            ACT_INT: begin
              sh_next      = int_al;
              cnt_next     = CNT_W'(NB);
              tail_en_next = 1'b0;
              state_next   = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // drop leading zero bytes one per cycle
        if (cnt != '0 && sh_top == 8'd0) begin
          sh_next  = sh << 8;
          cnt_next = cnt - CNT_W'(1);
        end else begin
          state_next = ST_HEAD;
          if (cnt == '0) begin
            head_next = STR_OFFSET;
          end else if (cnt == CNT_W'(1) && sh_top < SINGLE_MAX) begin
            head_next = sh_top;
            cnt_next  = '0;
          end else begin
            head_next = STR_OFFSET + 8'(cnt);
          end
        end
      end
      ST_HEAD: begin
        if (can_load) begin
          load      = 1'b1;
          load_byte = head_byte;
          load_last = (cnt == '0) && !tail_en;
          if (cnt != '0) begin
            state_next = ST_BODY;
          end else if (tail_en) begin
            state_next = ST_TAIL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_BODY: begin
        if (can_load) begin
          load      = 1'b1;
          load_byte = sh_top;
          load_last = (cnt == CNT_W'(1)) && !tail_en;
          sh_next   = sh << 8;
          cnt_next  = cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state_next = tail_en ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (can_load) begin
          load       = 1'b1;
          load_byte  = tail_byte;
          load_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    result_valid_next = load || (result_valid && !result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rem          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      rem          <= rem_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    sh        <= sh_next;
    head_byte <= head_next;
    tail_en   <= tail_en_next;
    tail_byte <= tail_next;
    if (load) begin
      result.out_byte <= load_byte;
      result.run_last <= load_last;
    end
  end

`ifndef SYNTHESIS
  a_open_string_count: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.action == ACT_STRING && rem != '0)
      |=> (rem == $past(rem) - LEN_BITS'(1)))
    else $error("open string count did not step down");

  a_other_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.action != ACT_STRING) |=> $stable(rem))
    else $error("list or integer request changed the open string count");

  a_body_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BODY) |-> (cnt != '0))
    else $error("body state with no bytes left");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (load && load_last) |=> (state == ST_IDLE))
    else $error("last byte loaded but sequencer not idle");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.action != ACT_NONE) |=> !item_ready)
    else $error("request taken while previous one still in work");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rlp_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  rlp_in_t  item = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  rlp_out_t result;

  rlp_out_t   expected_bytes[$];
  logic [7:0] encoded[$];
  logic [31:0] string_left = '0;
  int mismatches = 0;
  int stall_cycles = 0;
  bit steady = 1'b0;

  rlp_item_encoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void put_byte(logic [7:0] b);
    encoded = {encoded, b};
  endfunction

  // length prefix: short form below 56, else byte count then big-endian length
  function automatic void add_header(logic [31:0] len, logic [7:0] base);
    int n;
    if (len < SHORT_LIMIT) begin
      put_byte(base + len[7:0]);
    end else begin
      n = (len[31:24] != 0) ? 4 : (len[23:16] != 0) ? 3 : (len[15:8] != 0) ? 2 : 1;
      put_byte(base + LONG_BASE + 8'(n));
      for (int i = n - 1; i >= 0; i--) put_byte(8'(len >> (8 * i)));
    end
  endfunction

  function automatic void encode_item(rlp_in_t it);
    logic [255:0] value;
    int k;
    rlp_out_t e;
    encoded.delete();
    case (rlp_action_t'(it.action))
      ACT_STRING: begin
        if (string_left != 0) begin
          put_byte(it.data_byte);
          string_left = string_left - 1;
        end else if (it.item_length == 0) begin
          put_byte(STR_OFFSET);
        end else if (it.item_length == 1 && it.data_byte < SINGLE_MAX) begin
          put_byte(it.data_byte);
        end else begin
          add_header(it.item_length, STR_OFFSET);
          put_byte(it.data_byte);
          string_left = it.item_length - 1;
        end
      end
      ACT_LIST: add_header(it.item_length, LIST_OFFSET);
      ACT_INT: begin
        value = {it.value_word3, it.value_word2, it.value_word1, it.value_word0};
        k = 32;
        while (k > 0 && value[8 * (k - 1) +: 8] == 0) k--;
        if (k == 0) begin
          put_byte(STR_OFFSET);
        end else if (k == 1 && value[7:0] < SINGLE_MAX) begin
          put_byte(value[7:0]);
        end else begin
          put_byte(STR_OFFSET + 8'(k));
          for (int i = k - 1; i >= 0; i--) put_byte(value[8 * i +: 8]);
        end
      end
      default: ;
    endcase
    foreach (encoded[i]) begin
      e.out_byte = encoded[i];
      e.run_last = (i == encoded.size() - 1);
      expected_bytes = {expected_bytes, e};
    end
  endfunction

  // both channels are sampled mid-cycle, so a transfer seen here lands on the next edge
  always @(negedge clk) begin
    rlp_out_t want;
    if (!rst) begin
      if (item_valid && item_ready) encode_item(item);
      if (result_valid && result_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result byte %02h last %0b", result.out_byte, result.run_last);
        end else begin
          want = expected_bytes.pop_front();
          if (result.out_byte !== want.out_byte || result.run_last !== want.run_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       want.out_byte, want.run_last, result.out_byte, result.run_last);
          end
        end
      end
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles == STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 21);
  end

  function automatic rlp_in_t random_item();
    rlp_in_t it;
    it.action      = ACT_STRING;
    it.item_length = $urandom;
    it.data_byte   = 8'($urandom);
    it.value_word3 = {$urandom, $urandom};
    it.value_word2 = {$urandom, $urandom};
    it.value_word1 = {$urandom, $urandom};
    it.value_word0 = {$urandom, $urandom};
    return it;
  endfunction

  // called and returns at a rising edge; valid stays high for a back-to-back item
  task automatic send(rlp_in_t it);
    int gap;
    if (!steady && $urandom_range(99) < 21) begin
      gap = $urandom_range(1, 3);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(negedge clk); while (!item_ready);
    @(posedge clk);
  endtask

  task automatic send_string(logic [31:0] len, logic [7:0] data);
    rlp_in_t it;
    it = random_item();
    it.item_length = len;
    it.data_byte = data;
    send(it);
  endtask

  task automatic send_list(logic [31:0] len);
    rlp_in_t it;
    it = random_item();
    it.action = ACT_LIST;
    it.item_length = len;
    send(it);
  endtask

  task automatic send_int(logic [255:0] value);
    rlp_in_t it;
    it = random_item();
    it.action = ACT_INT;
    {it.value_word3, it.value_word2, it.value_word1, it.value_word0} = value;
    send(it);
  endtask

  task automatic send_unused();
    rlp_in_t it;
    it = random_item();
    it.action = ACT_NONE;
    send(it);
  endtask

  task automatic test_strings();
    send_string(32'd0, 8'hff);
    send_string(32'd1, 8'h00);
    send_string(32'd1, 8'h7f);
    send_string(32'd1, 8'h80);
    send_string(32'd1, 8'hff);
  endtask

  task automatic test_lists();
    send_list(32'd0);
    send_list(32'd55);
    send_list(32'd56);
    send_list(32'h0000_00ff);
    send_list(32'h0000_0100);
    send_list(32'h00ff_ffff);
    send_list(32'h0100_0000);
    send_list(32'hffff_ffff);
  endtask

  task automatic test_integers();
    send_int('0);
    send_int(256'h7f);
    send_int(256'h80);
    send_int(256'h100);
    send_int({256{1'b1}});
    send_int(256'd1 << 255);
    send_int({64'h1, 64'h0, 64'h0, 64'h0});
  endtask

  // list, integer and unused requests while a string is open, one more after it closes
  task automatic test_interleaved();
    send_string(32'd3, 8'h12);
    send_list(32'd4);
    send_string($urandom, 8'h80);
    send_int(256'hbeef);
    send_unused();
    send_string($urandom, 8'h00);
    send_unused();
  endtask

  task automatic test_random();
    rlp_in_t it;
    int r;
    int pick;
    int nbytes;
    logic [255:0] value;
    for (int n = 0; n < 290; n++) begin
      steady = (n >= 120 && n < 200);
      it = random_item();
      r = $urandom_range(99);
      if (string_left != 0 && r < 85) begin
        send(it);
      end else begin
        pick = $urandom_range(99);
        if (string_left == 0 && pick < 50) begin
          r = $urandom_range(99);
          if (r < 10) it.item_length = 0;
          else if (r < 35) it.item_length = 1;
          else if (r < 85) it.item_length = $urandom_range(2, 55);
          else if (r < 97) it.item_length = $urandom_range(56, 70);
          else it.item_length = $urandom_range(256, 280);
          send(it);
        end else if (pick < 70) begin
          it.action = ACT_LIST;
          it.item_length = (r < 50) ? 32'($urandom_range(0, 60))
                                    : it.item_length >> (8 * $urandom_range(0, 3));
          send(it);
        end else if (pick < 94) begin
          it.action = ACT_INT;
          nbytes = $urandom_range(0, 32);
          value = {it.value_word3, it.value_word2, it.value_word1, it.value_word0};
          for (int i = nbytes; i < 32; i++) value[8 * i +: 8] = 8'h00;
          if (nbytes > 0 && $urandom_range(1)) value[8 * (nbytes - 1) +: 8] |= 8'h01;
          {it.value_word3, it.value_word2, it.value_word1, it.value_word0} = value;
          send(it);
        end else begin
          it.action = ACT_NONE;
          send(it);
        end
      end
    end
    steady = 1'b0;
  endtask

  // longest length: the string never closes, so this runs last
  task automatic test_widest_string();
    send_string(32'hffff_ffff, 8'h5a);
    send_string(32'hffff_ffff, 8'ha5);
    send_int(256'h1234);
    send_string(32'h0, 8'h00);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_strings();
    test_lists();
    test_integers();
    test_interleaved();
    test_random();
    test_widest_string();
    item_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
